// ----- hw/rtl/servo_slew_ramp_macros.svh -----
// ----------------------------------------------------------------------------
// Servo slew ramp assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_RAMP_MACROS_SVH
`define SERVO_SLEW_RAMP_MACROS_SVH

// Same-cycle implication.
`define SSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp package
// Widths, reset values, operation and register codes, shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  localparam int unsigned PW_W       = 12;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned INT_W      = 16;
  localparam int unsigned ELAPSED_W  = 17;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PW_W-1:0]      MIN_PULSE_RST     = 12'd1000;
  localparam logic [PW_W-1:0]      HOME_PULSE_RST    = 12'd1500;
  localparam logic [PW_W-1:0]      MAX_PULSE_RST     = 12'd2000;
  localparam logic [STEP_W-1:0]    STEP_SIZE_RST     = 8'd1;
  localparam logic [INT_W-1:0]     STEP_INTERVAL_RST = 16'd2500;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = {ELAPSED_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_ATTACH = 3'd1,
    OP_DETACH = 3'd2,
    OP_HOME   = 3'd3,
    OP_MAX    = 3'd4,
    OP_MIN    = 3'd5,
    OP_RANDOM = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE     = 3'd0,
    CFG_HOME_PULSE    = 3'd1,
    CFG_MAX_PULSE     = 3'd2,
    CFG_STEP_SIZE     = 3'd3,
    CFG_STEP_INTERVAL = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PW_W-1:0]   min_pulse;
    logic [PW_W-1:0]   home_pulse;
    logic [PW_W-1:0]   max_pulse;
    logic [STEP_W-1:0] step_size;
    logic [INT_W-1:0]  step_interval;
  } cfg_t;

  // Contents of the input register stage.
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] operation;
    logic [PW_W-1:0] random_target;
  } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssr_in_if.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp input channel
// Valid/ready channel carrying one command or tick beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_in_if
  import ssr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [PW_W-1:0] random_target;

  modport source (output valid, output operation, output random_target, input ready);
  modport sink   (input valid, input operation, input random_target, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ssr_out_if.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp output channel
// Valid/ready channel carrying one result beat per input beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_out_if
  import ssr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PW_W-1:0] pulse_width;
  logic            pulse_write;
  logic            at_target;

  modport source (output valid, output pulse_width, output pulse_write, output at_target,
                  input ready);
  modport sink   (input valid, input pulse_width, input pulse_write, input at_target,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/servo_slew_ramp.sv -----
// Path: an accepted beat is held in the input register, and its result in the result register.
// Throughput: one beat per cycle while out_ch is not stalled; state updates in one pass per beat.
// The input register refills in the cycle that it drains, and the result register
// is replaced in the cycle that it is taken.
// Reset: asynchronous, active low; position and target at 1500, reached set, detached,
// elapsed count saturated, configuration registers at their default values.
// ----------------------------------------------------------------------------
// Servo slew ramp
// Rate-limited servo pulse width generator driven by command and tick beats.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_ramp
  import ssr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ssr_in_if.sink                     in_ch,
  ssr_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t  cfg;
  item_t item;
  logic  take;

  ssr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssr_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .take_i (take),
    .item_o (item)
  );

  ssr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .take_o (take),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ssr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp configuration registers
// Write-only register bank for pulse limits, step size and step interval.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_cfg_regs
  import ssr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_PULSE:     cfg_d.min_pulse     = cfg_wdata_i[PW_W-1:0];
        CFG_HOME_PULSE:    cfg_d.home_pulse    = cfg_wdata_i[PW_W-1:0];
        CFG_MAX_PULSE:     cfg_d.max_pulse     = cfg_wdata_i[PW_W-1:0];
        CFG_STEP_SIZE:     cfg_d.step_size     = cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_INTERVAL: cfg_d.step_interval = cfg_wdata_i[INT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse     <= MIN_PULSE_RST;
      cfg_q.home_pulse    <= HOME_PULSE_RST;
      cfg_q.max_pulse     <= MAX_PULSE_RST;
      cfg_q.step_size     <= STEP_SIZE_RST;
      cfg_q.step_interval <= STEP_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ssr_in_reg.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp input register
// Captures one input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_in_reg
  import ssr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssr_in_if.sink    in_ch,
  input  wire logic take_i,
  output item_t     item_o
);

  logic            valid_q, valid_d;
  logic [OP_W-1:0] op_q;
  logic [PW_W-1:0] rnd_q;
  logic            fire;

  // The stage refills in the same cycle that the core drains it.
  assign in_ch.ready = !valid_q || take_i;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q  <= in_ch.operation;
      rnd_q <= in_ch.random_target;
    end
  end

  assign item_o.valid         = valid_q;
  assign item_o.operation     = op_q;
  assign item_o.random_target = rnd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ssr_core.sv -----
// ----------------------------------------------------------------------------
// Servo slew ramp core
// Servo state, one-pass command and tick update, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_slew_ramp_macros.svh"

module ssr_core
  import ssr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  output logic       take_o,
  ssr_out_if.source  out_ch
);

  logic [PW_W-1:0]      position_q, position_d;
  logic [PW_W-1:0]      target_q, target_d;
  logic                 moving_down_q, moving_down_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 reached_q, reached_d;
  logic                 attached_q, attached_d;
  logic                 wrote_d;

  logic                 out_valid_q, out_valid_d;
  logic [PW_W-1:0]      pulse_width_q;
  logic                 pulse_write_q;
  logic                 at_target_q;

  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [PW_W:0]        down_lim;
  logic [PW_W:0]        up_sum;
  logic [PW_W-1:0]      step_next;
  logic [PW_W-1:0]      rnd_clamped;
  logic [PW_W-1:0]      new_target;
  logic                 set_tgt;

  assign take_o = item_i.valid && (!out_valid_q || out_ch.ready);

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign down_lim    = {1'b0, target_q} + {{(PW_W + 1 - STEP_W){1'b0}}, cfg_i.step_size};
  assign up_sum      = {1'b0, position_q} + {{(PW_W + 1 - STEP_W){1'b0}}, cfg_i.step_size};

  // A step never passes the target; a stale direction snaps onto it.
  always_comb begin
    if (moving_down_q) begin
      if ({1'b0, position_q} < down_lim) begin
        step_next = target_q;
      end else begin
        step_next = position_q - {{(PW_W - STEP_W){1'b0}}, cfg_i.step_size};
      end
    end else begin
      if (up_sum > {1'b0, target_q}) begin
        step_next = target_q;
      end else begin
        step_next = up_sum[PW_W-1:0];
      end
    end
  end

  // An inverted range collapses onto the lower limit.
  always_comb begin
    if (cfg_i.max_pulse < cfg_i.min_pulse || item_i.random_target < cfg_i.min_pulse) begin
      rnd_clamped = cfg_i.min_pulse;
    end else if (item_i.random_target > cfg_i.max_pulse) begin
      rnd_clamped = cfg_i.max_pulse;
    end else begin
      rnd_clamped = item_i.random_target;
    end
  end

  always_comb begin
    position_d    = position_q;
    target_d      = target_q;
    moving_down_d = moving_down_q;
    elapsed_d     = elapsed_q;
    reached_d     = reached_q;
    attached_d    = attached_q;
    wrote_d       = 1'b0;
    set_tgt       = 1'b0;
    new_target    = target_q;

    case (op_e'(item_i.operation))
      OP_TICK: begin
        elapsed_d = elapsed_inc;
        if (position_q == target_q) begin
          reached_d = 1'b1;
        end else if (elapsed_inc > {1'b0, cfg_i.step_interval}) begin
          position_d = step_next;
          elapsed_d  = '0;
          wrote_d    = attached_q;
        end
      end
      OP_ATTACH: begin
        position_d = cfg_i.home_pulse;
        target_d   = cfg_i.home_pulse;
        reached_d  = 1'b1;
        attached_d = 1'b1;
      end
      OP_DETACH: begin
        reached_d  = 1'b0;
        attached_d = 1'b0;
      end
      OP_HOME: begin
        set_tgt    = 1'b1;
        new_target = cfg_i.home_pulse;
      end
      OP_MAX: begin
        set_tgt    = 1'b1;
        new_target = cfg_i.max_pulse;
      end
      OP_MIN: begin
        set_tgt    = 1'b1;
        new_target = cfg_i.min_pulse;
      end
      OP_RANDOM: begin
        set_tgt    = 1'b1;
        new_target = rnd_clamped;
      end
      default: begin
      end
    endcase

    // An equal target counts as upward travel.
    if (set_tgt) begin
      target_d      = new_target;
      moving_down_d = new_target < position_q;
      reached_d     = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= HOME_PULSE_RST;
      target_q      <= HOME_PULSE_RST;
      moving_down_q <= 1'b0;
      elapsed_q     <= ELAPSED_MAX;
      reached_q     <= 1'b1;
      attached_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        position_q    <= position_d;
        target_q      <= target_d;
        moving_down_q <= moving_down_d;
        elapsed_q     <= elapsed_d;
        reached_q     <= reached_d;
        attached_q    <= attached_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      pulse_width_q <= position_d;
      pulse_write_q <= wrote_d;
      at_target_q   <= reached_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.pulse_width = pulse_width_q;
  assign out_ch.pulse_write = pulse_write_q;
  assign out_ch.at_target   = at_target_q;

  `SSR_ASSERT_IMP(a_reached_on_target, reached_q, position_q == target_q,
                  "reached flag set while position differs from target")
  `SSR_ASSERT_NXT(a_step_restarts_count, take_o && wrote_d, elapsed_q == '0,
                  "step did not restart the elapsed count")
  `SSR_ASSERT_NXT(a_attach_homes, take_o && op_e'(item_i.operation) == OP_ATTACH,
                  attached_q && position_q == target_q,
                  "attach did not home the servo")
  `SSR_ASSERT_NXT(a_stall_holds_state, out_valid_q && !out_ch.ready,
                  $stable(position_q) && $stable(elapsed_q),
                  "servo state changed while the result beat was stalled")

endmodule

`default_nettype wire

// ----- dv/tb_servo_slew_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew ramp testbench
// Drives command and tick beats into the ramp, mirrors the servo state in a
// local predictor and compares every result beat field by field, across a
// series of register settings with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_servo_slew_ramp;
  import ssr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 125;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PW_W-1:0] rnd;
  } servo_cmd_t;

  typedef struct packed {
    logic [PW_W-1:0] pulse_width;
    logic            pulse_write;
    logic            at_target;
  } pulse_beat_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic [OP_W-1:0]       in_op = '0;
  logic [PW_W-1:0]       in_rnd = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ssr_in_if  in_ch ();
  ssr_out_if out_ch ();

  assign in_ch.valid         = in_valid;
  assign in_ch.operation     = in_op;
  assign in_ch.random_target = in_rnd;
  assign out_ch.ready        = out_ready;

  servo_slew_ramp DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Mirror of the servo state and its registers.
  cfg_t srv_cfg = '{MIN_PULSE_RST, HOME_PULSE_RST, MAX_PULSE_RST, STEP_SIZE_RST,
                    STEP_INTERVAL_RST};
  logic [PW_W-1:0]      srv_pos      = HOME_PULSE_RST;
  logic [PW_W-1:0]      srv_tgt      = HOME_PULSE_RST;
  logic                 srv_down     = 1'b0;
  logic [ELAPSED_W-1:0] srv_elapsed  = ELAPSED_MAX;
  logic                 srv_reached  = 1'b1;
  logic                 srv_attached = 1'b0;

  servo_cmd_t  cmd_backlog[$];
  pulse_beat_t pulse_forecast[$];
  servo_cmd_t  cmd_next;
  pulse_beat_t pulse_want;

  int unsigned items_sent = 0;
  int unsigned items_taken = 0;
  int unsigned fails = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned hold_left = 0;
  logic        send_steady = 1'b0;
  logic        take_steady = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  logic        in_fire = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 12);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return OP_TICK;
    if (r < 61) return OP_ATTACH;
    if (r < 66) return OP_DETACH;
    if (r < 74) return OP_HOME;
    if (r < 82) return OP_MAX;
    if (r < 89) return OP_MIN;
    if (r < 98) return OP_RANDOM;
    return OP_UNUSED;
  endfunction

  function automatic void aim_at(logic [PW_W-1:0] t);
    srv_tgt     = t;
    srv_down    = t < srv_pos;
    srv_reached = 1'b0;
  endfunction

  function automatic pulse_beat_t ramp_update(logic [OP_W-1:0] op, logic [PW_W-1:0] rnd);
    pulse_beat_t res;
    logic [PW_W-1:0] pick;
    int nxt;
    res.pulse_write = 1'b0;
    pick = rnd;
    case (op)
      OP_TICK: begin
        if (srv_elapsed != ELAPSED_MAX) srv_elapsed = srv_elapsed + 1'b1;
        if (srv_pos == srv_tgt) begin
          srv_reached = 1'b1;
        end else if (srv_elapsed > srv_cfg.step_interval) begin
          // The clamp also snaps a position that lies behind the latched direction.
          if (srv_down) begin
            nxt = int'(srv_pos) - int'(srv_cfg.step_size);
            if (nxt < int'(srv_tgt)) nxt = int'(srv_tgt);
          end else begin
            nxt = int'(srv_pos) + int'(srv_cfg.step_size);
            if (nxt > int'(srv_tgt)) nxt = int'(srv_tgt);
          end
          srv_pos = nxt[PW_W-1:0];
          srv_elapsed = '0;
          res.pulse_write = srv_attached;
        end
      end
      OP_ATTACH: begin
        srv_pos      = srv_cfg.home_pulse;
        srv_tgt      = srv_cfg.home_pulse;
        srv_reached  = 1'b1;
        srv_attached = 1'b1;
      end
      OP_DETACH: begin
        srv_reached  = 1'b0;
        srv_attached = 1'b0;
      end
      OP_HOME: aim_at(srv_cfg.home_pulse);
      OP_MAX:  aim_at(srv_cfg.max_pulse);
      OP_MIN:  aim_at(srv_cfg.min_pulse);
      OP_RANDOM: begin
        if (srv_cfg.max_pulse < srv_cfg.min_pulse || rnd < srv_cfg.min_pulse) begin
          pick = srv_cfg.min_pulse;
        end else if (rnd > srv_cfg.max_pulse) begin
          pick = srv_cfg.max_pulse;
        end
        aim_at(pick);
      end
      default: ;
    endcase
    res.pulse_width = srv_pos;
    res.at_target   = srv_reached;
    return res;
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [PW_W-1:0] rnd);
    cmd_backlog.push_back('{op: op, rnd: rnd});
    items_sent++;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  // Returns at a falling edge once every sent beat has been taken and answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_taken != items_sent || pulse_forecast.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    case (idx)
      CFG_MIN_PULSE:     srv_cfg.min_pulse     = val[PW_W-1:0];
      CFG_HOME_PULSE:    srv_cfg.home_pulse    = val[PW_W-1:0];
      CFG_MAX_PULSE:     srv_cfg.max_pulse     = val[PW_W-1:0];
      CFG_STEP_SIZE:     srv_cfg.step_size     = val[STEP_W-1:0];
      CFG_STEP_INTERVAL: srv_cfg.step_interval = val[INT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Command driver.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cmd_next = cmd_backlog.pop_front();
        in_op    <= cmd_next.op;
        in_rnd   <= cmd_next.rnd;
        in_valid <= 1'b1;
        send_gap = send_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink ready, with an occasional long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (take_steady) begin
      out_ready <= 1'b1;
    end else if (take_gap > 0) begin
      take_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      take_gap = pick_gap();
    end
  end

  // Monitor: predicts on every accepted command beat, checks every result beat.
  always @(posedge clk_i) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        pulse_forecast.push_back(ramp_update(in_ch.operation, in_ch.random_target));
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pulse_forecast.size() == 0) begin
          $error("result beat with nothing outstanding: pulse_width %0d", out_ch.pulse_width);
          fails++;
        end else begin
          pulse_want = pulse_forecast.pop_front();
          check_field("pulse_width", pulse_want.pulse_width, out_ch.pulse_width);
          check_field("pulse_write", pulse_want.pulse_write, out_ch.pulse_write);
          check_field("at_target", pulse_want.at_target, out_ch.at_target);
        end
      end
    end
  end

  initial begin
    int unsigned lo, hi, tmp;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default settings: unused code, attach, aim at max, one step from the saturated count, detach.
    queue_cmd(OP_UNUSED, 12'hFFF);
    queue_cmd(OP_ATTACH, 12'h000);
    queue_cmd(OP_MAX, 12'h000);
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_DETACH, 12'h000);
    queue_cmd(OP_TICK, 12'hFFF);

    // Full range, largest step, no interval.
    write_reg(CFG_MIN_PULSE, 16'd0);
    write_reg(CFG_HOME_PULSE, 16'd2048);
    write_reg(CFG_MAX_PULSE, 16'd4095);
    write_reg(CFG_STEP_SIZE, 16'd255);
    write_reg(CFG_STEP_INTERVAL, 16'd0);
    queue_cmd(OP_ATTACH, 12'h000);
    queue_cmd(OP_HOME, 12'h000);   // target equal to position counts as upward
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_MAX, 12'h000);
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_RANDOM, 12'h000);
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_RANDOM, 12'hFFF);
    queue_cmd(OP_MIN, 12'h000);
    queue_cmd(OP_TICK, 12'h000);

    // Inverted range pins random targets to min; a zero step never moves.
    write_reg(CFG_MIN_PULSE, 16'd3000);
    write_reg(CFG_MAX_PULSE, 16'd1000);
    write_reg(CFG_HOME_PULSE, 16'd0);
    write_reg(CFG_STEP_SIZE, 16'd0);
    queue_cmd(OP_ATTACH, 12'h000);
    queue_cmd(OP_RANDOM, 12'hFFF);
    queue_cmd(OP_TICK, 12'h000);
    queue_cmd(OP_RANDOM, 12'h000);
    queue_cmd(OP_MAX, 12'h000);
    queue_cmd(OP_TICK, 12'h000);

    for (int p = 0; p < RAND_PHASES; p++) begin
      lo = $urandom_range(4095);
      hi = $urandom_range(4095);
      if (lo > hi && $urandom_range(9) != 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      write_reg(CFG_MIN_PULSE, CFG_DATA_W'(lo));
      write_reg(CFG_MAX_PULSE, CFG_DATA_W'(hi));
      write_reg(CFG_HOME_PULSE, CFG_DATA_W'($urandom_range(4095)));
      if (p == 4) begin
        write_reg(CFG_STEP_SIZE, 16'd0);
      end else if ($urandom_range(3) == 0) begin
        write_reg(CFG_STEP_SIZE, CFG_DATA_W'($urandom_range(255, 1)));
      end else begin
        write_reg(CFG_STEP_SIZE, CFG_DATA_W'($urandom_range(16, 1)));
      end
      if (p == 6) begin
        write_reg(CFG_STEP_INTERVAL, 16'd65535);
      end else if (p == 5) begin
        write_reg(CFG_STEP_INTERVAL, 16'd40);
      end else begin
        write_reg(CFG_STEP_INTERVAL, CFG_DATA_W'($urandom_range(3)));
      end

      send_steady = (p == 1 || p == 2);
      take_steady = (p == 1);
      // Stall the result side for a long stretch while commands keep coming.
      if (p == 2) hold_req = ~hold_req;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_cmd(pick_op(), PW_W'($urandom_range(4095)));
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
